@@ sv/descriptor_slot_allocator_assert.svh @@
// Assertion helpers for the descriptor slot allocator.
// Each expects clk and arst_n in scope.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define DSA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("descriptor slot allocator check failed");

// next-cycle implication
`define DSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("descriptor slot allocator check failed");

`endif

@@ sv/dsa_pkg.sv @@
`default_nettype none
package dsa_pkg;

	localparam int unsigned SLOT_W   = 10;
	localparam int unsigned CAP_W    = 11;
	localparam int unsigned STRIDE_W = 12;
	localparam int unsigned ADDR64_W = 64;
	localparam int unsigned OFF_W    = SLOT_W + STRIDE_W;
	localparam int unsigned PADDR_W  = 5;
	localparam int unsigned PDATA_W  = 64;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_RANGE = 2'd1,
		REQ_FREE  = 2'd2,
		REQ_QUERY = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_REJECTED  = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_CAPACITY    = 2'd0,
		REG_STRIDE      = 2'd1,
		REG_HOST_BASE   = 2'd2,
		REG_DEVICE_BASE = 2'd3
	} reg_index_t;

	localparam logic [CAP_W-1:0]    CAPACITY_RST = 11'd1024;
	localparam logic [STRIDE_W-1:0] STRIDE_RST   = 12'd32;

	typedef struct packed {
		logic [CAP_W-1:0]    capacity;
		logic [STRIDE_W-1:0] stride;
		logic [ADDR64_W-1:0] host_base;
		logic [ADDR64_W-1:0] device_base;
	} cfg_t;

endpackage
`default_nettype wire

@@ sv/descriptor_slot_allocator.sv @@
// Descriptor slot allocator.
// Request channel: req_valid/req_stall with req_type, range_count and slot_index.
// Response channel: rsp_valid/rsp_stall with slot_result, status, host_handle
// and device_handle; every request gives exactly one response, in order.
// Registers (capacity, stride, host and device base) sit on the APB port at
// byte offsets 0, 8, 16 and 24; write them only while no request is in flight.
// A request is captured in the input stage and its response is registered in
// the result stage. One request per cycle is sustained while rsp_stall is low;
// the free stack keeps its top entry in a register loaded ahead of use, so a
// pop can follow a push or a pop directly.
// When rsp_stall is high the response holds; one more request is still taken
// into the input stage, after which req_stall rises until the response drains.
// Reset empties the free stack, sets the bump pointer to 1 and loads register
// defaults; no clearing pass is needed and requests are taken right away.
`default_nettype none
module descriptor_slot_allocator import dsa_pkg::*; #(
	parameter int unsigned MAX_SLOTS = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [1:0]          req_type,
	input  wire logic [CAP_W-1:0]    range_count,
	input  wire logic [SLOT_W-1:0]   slot_index,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic [SLOT_W-1:0]        slot_result,
	output logic [1:0]               status,
	output logic [ADDR64_W-1:0]      host_handle,
	output logic [ADDR64_W-1:0]      device_handle,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready
);

	`include "descriptor_slot_allocator_assert.svh"

	localparam int unsigned ADDR_W  = $clog2(MAX_SLOTS);
	localparam int unsigned DEPTH_W = $clog2(MAX_SLOTS + 1);
	localparam int unsigned CAP_LIM = (MAX_SLOTS > 2047) ? 2047 : MAX_SLOTS;
	localparam logic [CAP_W-1:0]   CAP_LIM_V  = CAP_W'(CAP_LIM);
	localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(MAX_SLOTS);

	cfg_t cfg;

	dsa_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input stage
	logic              valid_s1;
	req_type_t         req_type_s1;
	logic [CAP_W-1:0]  range_count_s1;
	logic [SLOT_W-1:0] slot_index_s1;

	// result stage
	logic                rsp_valid_s2;
	logic [SLOT_W-1:0]   slot_result_s2;
	status_t             status_s2;
	logic [ADDR64_W-1:0] host_handle_s2;
	logic [ADDR64_W-1:0] device_handle_s2;

	// allocator state
	logic [DEPTH_W-1:0] depth_q;
	logic [CAP_W-1:0]   next_fresh_q;

	logic advance;
	logic process;

	assign advance   = !rsp_valid_s2 || !rsp_stall;
	assign process   = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_type_s1    <= req_type_t'(req_type);
			range_count_s1 <= range_count;
			slot_index_s1  <= slot_index;
		end
	end

	// request evaluation
	logic [CAP_W-1:0]    eff_cap;
	logic [CAP_W:0]      range_end;
	logic [OFF_W-1:0]    offset;
	logic [SLOT_W-1:0]   top;
	logic                push;
	logic [DEPTH_W-1:0]  depth_nxt;
	logic [CAP_W-1:0]    next_fresh_nxt;
	logic [SLOT_W-1:0]   slot_c;
	status_t             status_c;
	logic [ADDR64_W-1:0] host_c;
	logic [ADDR64_W-1:0] device_c;
	logic [DEPTH_W-1:0]  rd_ptr;

	assign eff_cap   = (cfg.capacity > CAP_LIM_V) ? CAP_LIM_V : cfg.capacity;
	assign range_end = {1'b0, next_fresh_q} + {1'b0, range_count_s1};
	assign offset    = OFF_W'(slot_index_s1) * OFF_W'(cfg.stride);

	always_comb begin
		push           = 1'b0;
		depth_nxt      = depth_q;
		next_fresh_nxt = next_fresh_q;
		slot_c         = '0;
		status_c       = ST_OK;
		host_c         = '0;
		device_c       = '0;
		case (req_type_s1)
			REQ_ALLOC: begin
				if (depth_q != '0) begin
					depth_nxt = depth_q - 1'b1;
					slot_c    = top;
				end else if (next_fresh_q >= eff_cap) begin
					status_c = ST_EXHAUSTED;
				end else begin
					slot_c         = next_fresh_q[SLOT_W-1:0];
					next_fresh_nxt = next_fresh_q + 1'b1;
				end
			end
			REQ_RANGE: begin
				if ((range_count_s1 == '0) || (range_end > {1'b0, eff_cap})) begin
					status_c = ST_EXHAUSTED;
				end else begin
					slot_c         = next_fresh_q[SLOT_W-1:0];
					next_fresh_nxt = range_end[CAP_W-1:0];
				end
			end
			REQ_FREE: begin
				if ((slot_index_s1 == '0) || ({1'b0, slot_index_s1} >= eff_cap)) begin
					status_c = ST_REJECTED;
				end else if (depth_q == DEPTH_FULL) begin
					status_c = ST_FULL;
				end else begin
					push      = 1'b1;
					depth_nxt = depth_q + 1'b1;
				end
			end
			default: begin
				slot_c   = slot_index_s1;
				host_c   = cfg.host_base + ADDR64_W'(offset);
				device_c = cfg.device_base + ADDR64_W'(offset);
			end
		endcase
		if (!process) begin
			push           = 1'b0;
			depth_nxt      = depth_q;
			next_fresh_nxt = next_fresh_q;
		end
	end

	// stack keeps entry (depth - 1) ready as the top for the next cycle
	assign rd_ptr = depth_nxt - 1'b1;

	dsa_free_stack #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_stack (
		.clk     (clk),
		.push    (push),
		.wr_addr (depth_q[ADDR_W-1:0]),
		.wr_data (slot_index_s1),
		.rd_addr (rd_ptr[ADDR_W-1:0]),
		.top     (top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= '0;
			next_fresh_q <= CAP_W'(1);
			rsp_valid_s2 <= 1'b0;
		end else begin
			depth_q      <= depth_nxt;
			next_fresh_q <= next_fresh_nxt;
			if (advance) begin
				rsp_valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			slot_result_s2   <= slot_c;
			status_s2        <= status_c;
			host_handle_s2   <= host_c;
			device_handle_s2 <= device_c;
		end
	end

	assign rsp_valid     = rsp_valid_s2;
	assign slot_result   = slot_result_s2;
	assign status        = status_s2;
	assign host_handle   = host_handle_s2;
	assign device_handle = device_handle_s2;

	`DSA_ASSERT_NOW(a_depth_bound, 1'b1, depth_q <= DEPTH_FULL)
	`DSA_ASSERT_NOW(a_fresh_nonzero, 1'b1, next_fresh_q != '0)
	`DSA_ASSERT_NOW(a_stall_needs_item, req_stall, valid_s1 && rsp_valid_s2)
	`DSA_ASSERT_NEXT(a_pop_depth,
		process && (req_type_s1 == REQ_ALLOC) && (depth_q != '0),
		(depth_q + 1'b1) == $past(depth_q))
	`DSA_ASSERT_NEXT(a_push_ok, push, (depth_q == $past(depth_q) + 1'b1) && (status_s2 == ST_OK))

endmodule
`default_nettype wire

@@ sv/dsa_cfg_regs.sv @@
`default_nettype none
module dsa_cfg_regs import dsa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic [CAP_W-1:0]    capacity_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [ADDR64_W-1:0] host_base_q;
	logic [ADDR64_W-1:0] device_base_q;
	reg_index_t          reg_sel;
	logic                wr_en;

	assign pready  = 1'b1;
	assign reg_sel = reg_index_t'(paddr[PADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= CAPACITY_RST;
			stride_q      <= STRIDE_RST;
			host_base_q   <= '0;
			device_base_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_CAPACITY:    capacity_q    <= pwdata[CAP_W-1:0];
				REG_STRIDE:      stride_q      <= pwdata[STRIDE_W-1:0];
				REG_HOST_BASE:   host_base_q   <= pwdata;
				REG_DEVICE_BASE: device_base_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_CAPACITY:    prdata = PDATA_W'(capacity_q);
			REG_STRIDE:      prdata = PDATA_W'(stride_q);
			REG_HOST_BASE:   prdata = host_base_q;
			REG_DEVICE_BASE: prdata = device_base_q;
			default:         prdata = '0;
		endcase
	end

	assign cfg.capacity    = capacity_q;
	assign cfg.stride      = stride_q;
	assign cfg.host_base   = host_base_q;
	assign cfg.device_base = device_base_q;

endmodule
`default_nettype wire

@@ sv/dsa_free_stack.sv @@
`default_nettype none
module dsa_free_stack import dsa_pkg::*; #(
	parameter int unsigned MAX_SLOTS = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          push,
	input  wire logic [$clog2(MAX_SLOTS)-1:0]  wr_addr,
	input  wire logic [SLOT_W-1:0]             wr_data,
	input  wire logic [$clog2(MAX_SLOTS)-1:0]  rd_addr,
	output logic      [SLOT_W-1:0]             top
);

	logic [SLOT_W-1:0] mem [MAX_SLOTS];
	logic [SLOT_W-1:0] top_q;

	// rd_addr is the next top of stack; a push to that entry is forwarded
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_addr] <= wr_data;
		end
		if (push && (wr_addr == rd_addr)) begin
			top_q <= wr_data;
		end else begin
			top_q <= mem[rd_addr];
		end
	end

	assign top = top_q;

endmodule
`default_nettype wire
